### hw/rtl/rst_pkg.sv
// Shared types, constants and clamp helpers for the road segment tracker.
// No dependencies.
`timescale 1ns / 1ps
package rst_pkg;

    localparam int unsigned WIDTH_CAP  = 1024;
    localparam int unsigned MAX_HEIGHT = 1024;
    localparam int unsigned MAX_ROWS   = 64;
    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    localparam logic [7:0] CLS_ROAD    = 8'd1;
    localparam logic [7:0] CLS_BARRIER = 8'd2;

    // register indexes
    localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [2:0] REG_SCAN_END     = 3'd2;
    localparam logic [2:0] REG_MARGIN       = 3'd3;
    localparam logic [2:0] REG_ROWS_NEEDED  = 3'd4;
    localparam logic [2:0] REG_ROAD_MIN     = 3'd5;
    localparam logic [2:0] REG_ROAD_MAX     = 3'd6;
    localparam logic [2:0] REG_BARRIER_MIN  = 3'd7;

    typedef struct packed {
        logic [10:0] frame_width;
        logic [10:0] frame_height;
        logic [9:0]  scan_end_row;
        logic [9:0]  window_margin;
        logic [6:0]  rows_needed;
        logic [10:0] road_width_min;
        logic [10:0] road_width_max;
        logic [10:0] barrier_width_min;
    } cfg_t;

    // request passed from the front to the back
    typedef struct packed {
        logic       row_valid;
        logic       eof;
        logic       found;
        logic       first;
        logic       mid;
        logic       last;
        logic       gap;
        logic [9:0] seg_start;
        logic [9:0] seg_end;
        logic [9:0] row_y;
        logic [9:0] ref_col;
    } rec_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_DIV,
        B_OUT
    } back_state_t;

    function automatic logic [10:0] eff_w(input logic [10:0] v);
        logic [10:0] r;
        r = v;
        if (v == 11'd0)
            r = 11'd1;
        else if (v > 11'(WIDTH_CAP))
            r = 11'(WIDTH_CAP);
        return r;
    endfunction

    function automatic logic [10:0] eff_h(input logic [10:0] v);
        logic [10:0] r;
        r = v;
        if (v == 11'd0)
            r = 11'd1;
        else if (v > 11'(MAX_HEIGHT))
            r = 11'(MAX_HEIGHT);
        return r;
    endfunction

    function automatic logic [6:0] eff_n(input logic [6:0] v);
        logic [6:0] r;
        r = v;
        if (v == 7'd0)
            r = 7'd1;
        else if (v > 7'(MAX_ROWS))
            r = 7'(MAX_ROWS);
        return r;
    endfunction

endpackage

### hw/rtl/rst_front.sv
// Pixel front end: counts pixels, finds runs in the window, picks each row's segment.
// Depends on rst_pkg.
`timescale 1ns / 1ps
module rst_front (
    input  logic          clk,
    input  logic          rst_n,
    input  rst_pkg::cfg_t cfg,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [7:0]    pixel_class,
    input  logic [9:0]    ref_center,
    input  logic          frame_first,
    output logic          push,
    output rst_pkg::rec_t rec,
    input  logic          full
);
    import rst_pkg::*;

    typedef struct packed {
        logic [7:0] run_value;
        logic [9:0] run_begin;
        logic       road_picked;
        logic [9:0] road_start;
        logic [9:0] road_end;
        logic       left_valid;
        logic [9:0] left_end;
        logic       right_valid;
        logic [9:0] right_start;
    } row_t;

    localparam row_t ROW_CLEAR = '0;

    logic [9:0] col_reg, col_next, row_reg, row_next, ref_reg, ref_next;
    logic [9:0] ws_reg, ws_next, we_reg, we_next;
    row_t       rs_reg, rs_next;
    logic [6:0] tc_reg, tc_next;
    logic       done_reg, done_next;

    function automatic row_t close_run(input row_t r, input logic [9:0] s,
                                       input logic [9:0] e, input logic [7:0] v,
                                       input logic [9:0] fref, input cfg_t c);
        row_t        o;
        logic [10:0] len;
        o   = r;
        len = 11'(e) - 11'(s) + 11'd1;
        if (v == CLS_ROAD)
        begin
            if (!r.road_picked && len >= c.road_width_min && len <= c.road_width_max)
            begin
                o.road_picked = 1'b1;
                o.road_start  = s;
                o.road_end    = e;
            end
        end
        else if (v == CLS_BARRIER && len >= c.barrier_width_min)
        begin
            if (e < fref && (!r.left_valid || e > r.left_end))
            begin
                o.left_valid = 1'b1;
                o.left_end   = e;
            end
            if (s > fref && (!r.right_valid || s < r.right_start))
            begin
                o.right_valid = 1'b1;
                o.right_start = s;
            end
        end
        return o;
    endfunction

    logic [10:0] w, h, hm1, wm1, gap_len, we_sum;
    logic [9:0]  se, x, y, cref, cws, cwe, s_sel, e_sel;
    logic        rowend, scanning, have, gap, cdone, last_row;
    logic [6:0]  ctc, n;
    row_t        r;

    assign in_ready = !full;

    always_comb
    begin
        w   = eff_w(cfg.frame_width);
        h   = eff_h(cfg.frame_height);
        n   = eff_n(cfg.rows_needed);
        wm1 = w - 11'd1;
        hm1 = h - 11'd1;
        se  = (11'(cfg.scan_end_row) < hm1) ? cfg.scan_end_row : hm1[9:0];

        x     = frame_first ? 10'd0 : col_reg;
        cref  = frame_first ? ref_center : ref_reg;
        cws   = frame_first ? 10'd0 : ws_reg;
        cwe   = frame_first ? wm1[9:0] : we_reg;
        r     = frame_first ? ROW_CLEAR : rs_reg;
        ctc   = frame_first ? 7'd0 : tc_reg;
        cdone = frame_first ? 1'b0 : done_reg;
        row_next = frame_first ? 10'd0 : row_reg;

        rowend   = 11'(x) >= wm1;
        scanning = !cdone && (11'(row_next) + 11'(se) <= hm1);
        last_row = 11'(row_next) >= hm1;
        y        = 10'(hm1 - 11'(row_next));

        ws_next   = cws;
        we_next   = cwe;
        tc_next   = ctc;
        done_next = cdone;
        have      = 1'b0;
        gap       = 1'b0;
        s_sel     = 10'd0;
        e_sel     = 10'd0;
        gap_len   = 11'd0;
        we_sum    = 11'd0;
        rec       = '0;

        if (scanning && x >= cws && x <= cwe)
        begin
            if (!(r.run_value != 8'd0 && pixel_class == r.run_value))
            begin
                if (r.run_value != 8'd0)
                    r = close_run(r, r.run_begin, x - 10'd1, r.run_value, cref, cfg);
                r.run_value = pixel_class;
                r.run_begin = x;
            end
            if ((x == cwe || rowend) && r.run_value != 8'd0)
            begin
                r = close_run(r, r.run_begin, x, r.run_value, cref, cfg);
                r.run_value = 8'd0;
            end
        end

        if (scanning && rowend)
        begin
            if (r.road_picked)
            begin
                have  = 1'b1;
                s_sel = r.road_start;
                e_sel = r.road_end;
            end
            else if (r.left_valid && r.right_valid)
            begin
                gap_len = 11'(r.right_start) - 11'(r.left_end) - 11'd1;
                if (gap_len >= cfg.road_width_min && gap_len <= cfg.road_width_max)
                begin
                    have  = 1'b1;
                    gap   = 1'b1;
                    s_sel = r.left_end + 10'd1;
                    e_sel = r.right_start - 10'd1;
                end
            end
            if (have)
            begin
                rec.row_valid = 1'b1;
                rec.first     = (ctc == 7'd0);
                rec.mid       = (ctc == (n >> 1));
                tc_next       = ctc + 7'd1;
                if (tc_next >= n)
                begin
                    rec.last  = 1'b1;
                    done_next = 1'b1;
                end
                else
                begin
                    ws_next = (s_sel >= cfg.window_margin) ? s_sel - cfg.window_margin : 10'd0;
                    we_sum  = 11'(e_sel) + 11'(cfg.window_margin);
                    we_next = (we_sum > wm1) ? wm1[9:0] : we_sum[9:0];
                end
            end
            else
            begin
                tc_next = 7'd0;
                ws_next = 10'd0;
                we_next = wm1[9:0];
            end
        end
        rec.gap       = gap;
        rec.seg_start = s_sel;
        rec.seg_end   = e_sel;
        rec.row_y     = y;
        rec.ref_col   = cref;
        rec.found     = done_next;

        rs_next  = rowend ? ROW_CLEAR : r;
        ref_next = cref;
        col_next = x + 10'd1;
        if (rowend)
        begin
            col_next = 10'd0;
            if (last_row)
            begin
                rec.eof   = 1'b1;
                row_next  = 10'd0;
                tc_next   = 7'd0;
                ws_next   = 10'd0;
                we_next   = wm1[9:0];
                done_next = 1'b0;
            end
            else
                row_next = row_next + 10'd1;
        end
        push = in_valid && in_ready && (rec.row_valid || rec.eof);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            ref_reg  <= '0;
            ws_reg   <= '0;
            we_reg   <= 10'd639;
            rs_reg   <= ROW_CLEAR;
            tc_reg   <= '0;
            done_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            ref_reg  <= ref_next;
            ws_reg   <= ws_next;
            we_reg   <= we_next;
            rs_reg   <= rs_next;
            tc_reg   <= tc_next;
            done_reg <= done_next;
        end
    end

endmodule

### hw/rtl/rst_queue.sv
// Short request queue between the front and the back.
// Depends on rst_pkg.
`timescale 1ns / 1ps
module rst_queue #(
    parameter int unsigned DEPTH = rst_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  rst_pkg::rec_t wr_data,
    output logic          full,
    input  logic          pop,
    output logic          rd_valid,
    output rst_pkg::rec_t rd_data
);
    import rst_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    rec_t          mem_reg [DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [CW-1:0] cnt_reg;

    assign full     = (cnt_reg == CW'(DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
            mem_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push && !full)
                wp_reg <= (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + AW'(1);
            if (pop && rd_valid)
                rp_reg <= (rp_reg == AW'(DEPTH - 1)) ? '0 : rp_reg + AW'(1);
            cnt_reg <= cnt_reg + CW'(push && !full) - CW'(pop && rd_valid);
        end
    end

endmodule

### hw/rtl/rst_back.sv
// Back end: accumulates tracked rows, divides the centre sum, drives the result register.
// Depends on rst_pkg.
`timescale 1ns / 1ps
module rst_back (
    input  logic          clk,
    input  logic          rst_n,
    input  rst_pkg::cfg_t cfg,
    input  logic          rd_valid,
    input  rst_pkg::rec_t rd_data,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [79:0]   out_data
);
    import rst_pkg::*;

    back_state_t st_reg, st_next;

    logic signed [17:0] sum_reg;
    logic [10:0] wmin_reg, wmax_reg;
    logic [9:0]  left_reg, right_reg, mid_reg, ref_reg;
    logic        gap_reg;
    logic        eof_pend_reg, found_reg;

    logic [16:0] dvd_reg;
    logic [7:0]  rem_reg;
    logic [4:0]  cnt_reg;
    logic        neg_reg;

    logic signed [10:0] res_dev_reg;
    logic signed [11:0] res_ctr_reg;
    logic [9:0]  res_mid_reg, res_left_reg, res_right_reg;
    logic [10:0] res_wmin_reg, res_wmax_reg;
    logic        res_gap_reg;

    logic        ov_reg;
    logic [79:0] od_reg;

    logic [10:0] w, seg_w;
    logic [6:0]  n;
    logic signed [17:0] sum_b, sum_n;
    logic [10:0] wmin_b, wmax_b;
    logic [9:0]  left_b, right_b, mid_b;
    logic        gap_b;
    logic [8:0]  rem_sh;
    logic [10:0] q11;
    logic signed [10:0] dev;
    logic        slot_free;

    assign out_valid = ov_reg;
    assign out_data  = od_reg;
    assign slot_free = !ov_reg || out_ready;

    always_comb
    begin
        w      = eff_w(cfg.frame_width);
        n      = eff_n(cfg.rows_needed);
        sum_b  = rd_data.first ? 18'sd0 : sum_reg;
        wmin_b = rd_data.first ? w : wmin_reg;
        wmax_b = rd_data.first ? 11'd0 : wmax_reg;
        left_b = rd_data.first ? 10'(w - 11'd1) : left_reg;
        right_b = rd_data.first ? 10'd0 : right_reg;
        mid_b  = rd_data.first ? 10'd0 : mid_reg;
        gap_b  = rd_data.first ? 1'b0 : gap_reg;
        seg_w  = 11'(rd_data.seg_end) - 11'(rd_data.seg_start) + 11'd1;
        sum_n  = sum_b
               + $signed({8'd0, 10'((11'(rd_data.seg_start) + 11'(rd_data.seg_end)) >> 1)})
               - $signed({8'd0, rd_data.ref_col});
        rem_sh = {rem_reg, dvd_reg[16]};
        q11    = dvd_reg[10:0];
        dev    = neg_reg ? -$signed(q11) : $signed(q11);
        pop    = (st_reg == B_IDLE) && rd_valid;
        st_next = st_reg;
        case (st_reg)
            B_IDLE:
                if (rd_valid)
                begin
                    if (rd_data.row_valid && rd_data.last)
                        st_next = B_DIV;
                    else if (rd_data.eof)
                        st_next = B_OUT;
                end
            B_DIV:
                if (cnt_reg == 5'd0)
                    st_next = eof_pend_reg ? B_OUT : B_IDLE;
            B_OUT:
                if (slot_free)
                    st_next = B_IDLE;
            default:
                st_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= B_IDLE;
            ov_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (st_reg == B_OUT && slot_free)
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            eof_pend_reg <= rd_data.eof;
            found_reg    <= rd_data.found;
            if (rd_data.row_valid)
            begin
                sum_reg   <= sum_n;
                wmin_reg  <= (seg_w < wmin_b) ? seg_w : wmin_b;
                wmax_reg  <= (seg_w > wmax_b) ? seg_w : wmax_b;
                left_reg  <= (rd_data.seg_start < left_b) ? rd_data.seg_start : left_b;
                right_reg <= (rd_data.seg_end > right_b) ? rd_data.seg_end : right_b;
                mid_reg   <= rd_data.mid ? rd_data.row_y : mid_b;
                gap_reg   <= gap_b | rd_data.gap;
                ref_reg   <= rd_data.ref_col;
                // load the divider with the magnitude of the new sum
                dvd_reg   <= sum_n[17] ? 17'(-sum_n) : sum_n[16:0];
                neg_reg   <= sum_n[17];
                rem_reg   <= 8'd0;
                cnt_reg   <= 5'd17;
            end
        end
        else if (st_reg == B_DIV)
        begin
            if (cnt_reg != 5'd0)
            begin
                if (rem_sh >= 9'(n))
                begin
                    rem_reg <= 8'(rem_sh - 9'(n));
                    dvd_reg <= {dvd_reg[15:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh[7:0];
                    dvd_reg <= {dvd_reg[15:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 5'd1;
            end
            else
            begin
                res_dev_reg   <= dev;
                res_ctr_reg   <= $signed({2'b00, ref_reg}) + 12'(dev);
                res_mid_reg   <= mid_reg;
                res_left_reg  <= left_reg;
                res_right_reg <= right_reg;
                res_wmin_reg  <= wmin_reg;
                res_wmax_reg  <= wmax_reg;
                res_gap_reg   <= gap_reg;
            end
        end
        if (st_reg == B_OUT && slot_free)
        begin
            if (found_reg)
                od_reg <= {3'd0, res_gap_reg, res_wmax_reg, res_wmin_reg, res_right_reg,
                           res_left_reg, res_mid_reg, res_ctr_reg, res_dev_reg, 1'b1};
            else
                od_reg <= '0;
        end
    end

endmodule

### hw/rtl/road_segment_tracker.sv
// Top level of the road segment tracker: configuration registers, front, queue and back.
// Depends on rst_pkg, rst_front, rst_queue and rst_back.
`timescale 1ns / 1ps
//
// Channel   Direction  Handshake              Carries
// s_*       in         s_tvalid / s_tready    one mask pixel, frame start flag in s_tuser
// m_*       out        m_tvalid / m_tready    one frame result per frame
// APB       in         psel, penable, pwrite  eight 32-bit configuration registers
//
// Pixels are taken one per clock while the request queue has room.
// A row that completes tracking holds the back end in its 17-step divider; other rows
// pop at once when idle, so the queue absorbs short bursts and stalls s_tready.
// The result sits in an output register; a stalled m_tready holds the back end directly.
// Reset clears counters and the queue; registers return to their documented defaults.
module road_segment_tracker #(
    parameter int unsigned QUEUE_DEPTH = rst_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] pixel_class, [17:8] ref_center, rest zero
    input  logic        s_tuser,   // [0] frame_first
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // found, deviation, center_col, mid_row, left_col,
                                   // right_col, width_min, width_max, gap_used
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rst_pkg::*;

    cfg_t cfg_reg;
    rec_t rec, q_data;
    logic push, full, pop, q_valid;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign idx    = paddr[4:2];

    // take a register write on the access cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width       <= 11'd640;
            cfg_reg.frame_height      <= 11'd480;
            cfg_reg.scan_end_row      <= 10'd0;
            cfg_reg.window_margin     <= 10'd20;
            cfg_reg.rows_needed       <= 7'd5;
            cfg_reg.road_width_min    <= 11'd20;
            cfg_reg.road_width_max    <= 11'd400;
            cfg_reg.barrier_width_min <= 11'd3;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (idx)
                REG_FRAME_WIDTH:  cfg_reg.frame_width       <= pwdata[10:0];
                REG_FRAME_HEIGHT: cfg_reg.frame_height      <= pwdata[10:0];
                REG_SCAN_END:     cfg_reg.scan_end_row      <= pwdata[9:0];
                REG_MARGIN:       cfg_reg.window_margin     <= pwdata[9:0];
                REG_ROWS_NEEDED:  cfg_reg.rows_needed       <= pwdata[6:0];
                REG_ROAD_MIN:     cfg_reg.road_width_min    <= pwdata[10:0];
                REG_ROAD_MAX:     cfg_reg.road_width_max    <= pwdata[10:0];
                REG_BARRIER_MIN:  cfg_reg.barrier_width_min <= pwdata[10:0];
                default:          ;
            endcase
        end
    end

    // return the addressed register, zero-extended
    always_comb
    begin
        case (idx)
            REG_FRAME_WIDTH:  prdata = 32'(cfg_reg.frame_width);
            REG_FRAME_HEIGHT: prdata = 32'(cfg_reg.frame_height);
            REG_SCAN_END:     prdata = 32'(cfg_reg.scan_end_row);
            REG_MARGIN:       prdata = 32'(cfg_reg.window_margin);
            REG_ROWS_NEEDED:  prdata = 32'(cfg_reg.rows_needed);
            REG_ROAD_MIN:     prdata = 32'(cfg_reg.road_width_min);
            REG_ROAD_MAX:     prdata = 32'(cfg_reg.road_width_max);
            REG_BARRIER_MIN:  prdata = 32'(cfg_reg.barrier_width_min);
            default:          prdata = 32'd0;
        endcase
    end

    rst_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .pixel_class (s_tdata[7:0]),
        .ref_center  (s_tdata[17:8]),
        .frame_first (s_tuser),
        .push        (push),
        .rec         (rec),
        .full        (full)
    );

    rst_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_data  (rec),
        .full     (full),
        .pop      (pop),
        .rd_valid (q_valid),
        .rd_data  (q_data)
    );

    rst_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .rd_valid  (q_valid),
        .rd_data   (q_data),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule

### hw/rtl/rst_checker.sv
// Port-level checks for the road segment tracker, bound to the top level.
// Depends on road_segment_tracker.
`timescale 1ns / 1ps
module rst_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [79:0] m_tdata,
    input logic        pready
);
    // hold a stalled result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> m_tdata[76:1] == 76'd0)
        else $error("empty result carries data");

    a_gap: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[76] |-> m_tdata[0])
        else $error("gap flag without a found result");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready dropped");
endmodule

bind road_segment_tracker rst_checker u_rst_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .pready   (pready)
);
